FILE: design/gbn_pkg.sv
// Shared types, constants and codes for the go-back-n send window.
package gbn_pkg;

  // Ring geometry and field widths
  localparam int RING_DEPTH    = 16;
  localparam int SLOT_W        = $clog2(RING_DEPTH);
  localparam int CNT_W         = $clog2(RING_DEPTH + 1);
  localparam int SEG_BYTES_MAX = 1024;
  localparam int LEN_W         = 11;
  localparam int SEQ_W         = 32;
  localparam int ACT_W         = 2;
  localparam int KIND_W        = 2;

  // Configuration port
  localparam int WIN_W      = 5;
  localparam int TMO_W      = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TMO_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = 5'd8;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 20'd1000;

  // Command queue between front and engine
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Input action codes
  localparam logic [ACT_W-1:0] ACT_QUEUE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [LEN_W-1:0] seg_length;
    logic [SEQ_W-1:0] ack_num;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq_num;
    logic [LEN_W-1:0]  out_length;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_QUEUE,
    OP_ACK,
    OP_TICK
  } op_t;

  // Classified command handed from front to engine
  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
  } cmd_t;

  // Configuration write strobe and payload
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUEUE,
    ST_SEND_WAIT,
    ST_SEND,
    ST_ACK_TEST,
    ST_ACK_FREE,
    ST_TICK_CHK,
    ST_RTX
  } eng_state_t;

endpackage

FILE: design/go_back_n_send_window.sv
// Go-back-n send window top level: front end, command queue and engine.
//
// Each input transaction queues a segment, applies a cumulative ack or
// advances time by one tick; results are segment descriptors to transmit
// (first send or retransmission) or a ring-full rejection, the final one of
// each transaction flagged by last. Inputs pass through a four-entry command
// queue, so a few transactions are taken while the engine works or the
// output is stalled. The engine handles one transaction at a time and is
// bounded by the single read port of its 16-entry descriptor memory: a
// queue item appends its descriptor and then sends one segment at a time
// while the window has room, an ack frees covered in-flight entries one at
// a time and then sends, and a tick with segments in flight checks the
// head's age and on timeout resends every segment in flight.
// Unknown action codes are dropped at the front and cost the engine nothing.
// Output stalls hold the engine. Configuration writes are meant for when
// the block is idle.
module go_back_n_send_window import gbn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    q_full, q_push, q_valid, q_pop;
  cmd_t    q_cmd, q_head;
  cfg_wr_t cfg_wr;

  // Registers are always writable
  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  gbn_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  gbn_cmd_queue u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head_cmd (q_head)
  );

  gbn_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: design/gbn_front.sv
// Front end: accepts input transactions, classifies them and clamps lengths.
module gbn_front import gbn_pkg::*; (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic             accept;
  logic [LEN_W-1:0] len_clamped;
  logic             known;

  // Stall only when the command queue cannot take another entry
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Saturate oversized segment lengths
  assign len_clamped = (in_data.seg_length > LEN_W'(SEG_BYTES_MAX)) ?
                       LEN_W'(SEG_BYTES_MAX) : in_data.seg_length;

  // Classify the action; unknown codes are dropped here
  always_comb begin
    known    = 1'b1;
    q_cmd.op = OP_QUEUE;
    unique case (in_data.action)
      ACT_QUEUE: q_cmd.op = OP_QUEUE;
      ACT_ACK:   q_cmd.op = OP_ACK;
      ACT_TICK:  q_cmd.op = OP_TICK;
      default:   known    = 1'b0;
    endcase
    q_cmd.len = len_clamped;
    q_cmd.ack = in_data.ack_num;
  end

  assign q_push = accept && known;

endmodule

FILE: design/gbn_cmd_queue.sv
// Short command queue that decouples the front end from the engine.
module gbn_cmd_queue import gbn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head_cmd
);

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full     = (count_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign valid    = (count_r != '0);
  assign head_cmd = slots[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the command payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/gbn_engine.sv
// Back end: ring state, descriptor memory, send/ack/retransmit sequencer.
module gbn_engine import gbn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg_wr,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Descriptor memory, one write and one registered read per cycle
  logic [SEQ_W-1:0] seq_mem   [RING_DEPTH];
  logic [LEN_W-1:0] len_mem   [RING_DEPTH];
  logic [SEQ_W-1:0] stamp_mem [RING_DEPTH];
  logic [SEQ_W-1:0] rd_seq_r;
  logic [LEN_W-1:0] rd_len_r;
  logic [SEQ_W-1:0] rd_stamp_r;

  eng_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] unsent_r, unsent_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic [CNT_W-1:0]  inflight_r, inflight_nxt;
  logic [SEQ_W-1:0]  next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]  now_r, now_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [SEQ_W-1:0]  ack_r, ack_nxt;
  logic [WIN_W-1:0]  window_r;
  logic [TMO_W-1:0]  timeout_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              desc_we, stamp_we;
  logic [SLOT_W-1:0] wr_addr, rd_addr;
  logic [SEQ_W-1:0]  wr_stamp;
  logic              out_free;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] rtx_slot;
  logic [CNT_W-1:0]  infl_inc;
  logic [CNT_W-1:0]  idx_inc;
  logic              can_send;
  logic              free_head;
  logic [SEQ_W-1:0]  elapsed;

  assign out_free  = !out_valid_r || !out_stall;
  assign tail      = head_r + stored_r[SLOT_W-1:0];
  assign rtx_slot  = head_r + idx_r;
  assign infl_inc  = inflight_r + 1'b1;
  assign idx_inc   = CNT_W'(idx_r) + 1'b1;
  assign can_send  = (inflight_r < CNT_W'(window_r)) && (inflight_r < stored_r);
  assign free_head = (inflight_r != '0) && (rd_seq_r < ack_r);
  assign elapsed   = now_r - rd_stamp_r;

  // Sequencer: next state, ring pointers, memory strobes and result
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    unsent_nxt    = unsent_r;
    idx_nxt       = idx_r;
    stored_nxt    = stored_r;
    inflight_nxt  = inflight_r;
    next_seq_nxt  = next_seq_r;
    now_nxt       = now_r;
    len_nxt       = len_r;
    ack_nxt       = ack_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    desc_we       = 1'b0;
    stamp_we      = 1'b0;
    wr_addr       = tail;
    wr_stamp      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_QUEUE: begin
              len_nxt   = cmd.len;
              state_nxt = ST_QUEUE;
            end
            OP_ACK: begin
              ack_nxt   = cmd.ack;
              state_nxt = (stored_r == '0) ? ST_IDLE : ST_ACK_TEST;
            end
            OP_TICK: begin
              now_nxt   = now_r + 1'b1;
              state_nxt = (inflight_r == '0) ? ST_IDLE : ST_TICK_CHK;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // Append a segment, or reject when the ring is full
      ST_QUEUE: begin
        if (stored_r >= CNT_W'(RING_DEPTH)) begin
          if (out_free) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.kind       = KIND_REJECT;
            out_data_nxt.seq_num    = next_seq_r;
            out_data_nxt.out_length = len_r;
            out_data_nxt.slot       = '0;
            out_data_nxt.last       = 1'b1;
            state_nxt               = ST_IDLE;
          end
        end else begin
          desc_we      = 1'b1;
          stamp_we     = 1'b1;
          wr_addr      = tail;
          wr_stamp     = '0;
          next_seq_nxt = next_seq_r + SEQ_W'(len_r);
          stored_nxt   = stored_r + 1'b1;
          state_nxt    = ST_SEND_WAIT;
        end
      end

      // Let the freshly written descriptor reach the read port
      ST_SEND_WAIT: begin
        state_nxt = ST_SEND;
      end

      // Transmit unsent entries while the window has room
      ST_SEND: begin
        if (!can_send) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          stamp_we                = 1'b1;
          wr_addr                 = unsent_r;
          wr_stamp                = now_r;
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = KIND_FIRST;
          out_data_nxt.seq_num    = rd_seq_r;
          out_data_nxt.out_length = rd_len_r;
          out_data_nxt.slot       = unsent_r;
          out_data_nxt.last       = !((infl_inc < CNT_W'(window_r)) &&
                                      (infl_inc < stored_r));
          inflight_nxt            = infl_inc;
          unsent_nxt              = unsent_r + 1'b1;
        end
      end

      // Drop an ack below the head, else free the first covered entry if any
      ST_ACK_TEST: begin
        if (ack_r < rd_seq_r) begin
          state_nxt = ST_IDLE;
        end else if (free_head) begin
          head_nxt     = head_r + 1'b1;
          inflight_nxt = inflight_r - 1'b1;
          stored_nxt   = stored_r - 1'b1;
          state_nxt    = ST_ACK_FREE;
        end else begin
          state_nxt = ST_SEND;
        end
      end

      // Free acknowledged in-flight entries one per cycle
      ST_ACK_FREE: begin
        if (free_head) begin
          head_nxt     = head_r + 1'b1;
          inflight_nxt = inflight_r - 1'b1;
          stored_nxt   = stored_r - 1'b1;
        end else begin
          state_nxt = ST_SEND;
        end
      end

      // Check the head's age against the timeout
      ST_TICK_CHK: begin
        if (elapsed > SEQ_W'(timeout_r)) begin
          idx_nxt   = '0;
          state_nxt = ST_RTX;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      // Resend every in-flight entry and restamp it
      ST_RTX: begin
        if (out_free) begin
          stamp_we                = 1'b1;
          wr_addr                 = rtx_slot;
          wr_stamp                = now_r;
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = KIND_RETX;
          out_data_nxt.seq_num    = rd_seq_r;
          out_data_nxt.out_length = rd_len_r;
          out_data_nxt.slot       = rtx_slot;
          out_data_nxt.last       = (idx_inc == inflight_r);
          if (idx_inc == inflight_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Read the entry the next state works on
  always_comb begin
    unique case (state_nxt)
      ST_SEND: rd_addr = unsent_nxt;
      ST_RTX:  rd_addr = head_nxt + idx_nxt;
      default: rd_addr = head_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (desc_we) begin
      seq_mem[wr_addr] <= next_seq_r;
      len_mem[wr_addr] <= len_r;
    end
    if (stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    rd_seq_r   <= seq_mem[rd_addr];
    rd_len_r   <= len_mem[rd_addr];
    rd_stamp_r <= stamp_mem[rd_addr];
  end

  // Control and ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      unsent_r    <= '0;
      idx_r       <= '0;
      stored_r    <= '0;
      inflight_r  <= '0;
      next_seq_r  <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      unsent_r    <= unsent_nxt;
      idx_r       <= idx_nxt;
      stored_r    <= stored_nxt;
      inflight_r  <= inflight_nxt;
      next_seq_r  <= next_seq_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold command operands and the output payload
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    ack_r      <= ack_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        CFG_WINDOW:  window_r  <= cfg_wr.data[WIN_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_wr.data[TMO_W-1:0];
        default:     window_r  <= window_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/gbn_checker.sv
// Port-level checker for the go-back-n send window, bound to the top level.
module gbn_checker import gbn_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A rejection stands alone at slot zero
  a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_REJECT) |-> out_data.last && (out_data.slot == '0))
    else $error("rejection not a lone result at slot zero");

  // Segment lengths stay saturated
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_length <= LEN_W'(SEG_BYTES_MAX)))
    else $error("result length above maximum");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind go_back_n_send_window gbn_checker u_gbn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the go-back-n send window: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import gbn_pkg::*;

  // Action code the block does not define; it must be dropped
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS   = 10;

  localparam out_item_t NO_TX = '0;

  // One directed transaction; tx is the typed expectation when typed is set
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t tx;
  } dir_row_t;

  // One random phase: register settings and transaction mix
  typedef struct packed {
    logic [WIN_W-1:0] win;
    logic [TMO_W-1:0] tmo;
    logic [7:0]       queue_pct;
    logic [7:0]       ack_pct;
    logic [9:0]       items;
  } phase_t;

  localparam int NUM_DIR = 25;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // extremes of the segment length, first sends straight after reset
    '{'{ACT_QUEUE, 11'd1, 32'd0}, 1'b1, '{KIND_FIRST, 32'd0, 11'd1, 4'd0, 1'b1}},
    '{'{ACT_QUEUE, 11'd1024, 32'd0}, 1'b1, '{KIND_FIRST, 32'd1, 11'd1024, 4'd1, 1'b1}},
    '{'{ACT_QUEUE, 11'd2047, 32'd0}, 1'b1, '{KIND_FIRST, 32'd1025, 11'd1024, 4'd2, 1'b1}},
    '{'{ACT_QUEUE, 11'd0, 32'd0}, 1'b1, '{KIND_FIRST, 32'd2049, 11'd0, 4'd3, 1'b1}},
    '{'{ACT_QUEUE, 11'd1025, 32'd0}, 1'b1, '{KIND_FIRST, 32'd2049, 11'd1024, 4'd4, 1'b1}},
    // acks that free nothing, free one, unknown action, ack below the head, a tick
    '{'{ACT_ACK, 11'd0, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_ACK, 11'd0, 32'd1}, 1'b0, NO_TX},
    '{'{ACT_UNUSED, 11'h7FF, 32'hFFFF_FFFF}, 1'b0, NO_TX},
    '{'{ACT_ACK, 11'h7FF, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_TICK, 11'd0, 32'd0}, 1'b0, NO_TX},
    // fill the window, then the ring
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    '{'{ACT_QUEUE, 11'd16, 32'd0}, 1'b0, NO_TX},
    // ring full: rejected with the running sequence number
    '{'{ACT_QUEUE, 11'd2047, 32'd0}, 1'b1, '{KIND_REJECT, 32'd3265, 11'd1024, 4'd0, 1'b1}},
    // ack covering unsent data, then ack clearing the ring
    '{'{ACT_ACK, 11'd0, 32'hFFFF_FFFF}, 1'b0, NO_TX},
    '{'{ACT_ACK, 11'd0, 32'h8000_0000}, 1'b0, NO_TX}
  };

  localparam int NUM_PHASES = 7;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{5'd16, 20'd3, 8'd50, 8'd25, 10'd60},
    '{5'd1, 20'd1, 8'd40, 8'd30, 10'd50},
    '{5'd4, 20'd1048575, 8'd55, 8'd25, 10'd50},
    '{5'd0, 20'd6, 8'd40, 8'd20, 10'd25},
    '{5'd16, 20'd2, 8'd35, 8'd35, 10'd50},
    '{5'd7, 20'd12, 8'd45, 8'd25, 10'd60},
    '{5'd8, 20'd5, 8'd45, 8'd30, 10'd60}
  };

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Sender state as predicted
  logic [SEQ_W-1:0]  ring_seq   [RING_DEPTH];
  logic [LEN_W-1:0]  ring_len   [RING_DEPTH];
  logic [SEQ_W-1:0]  ring_stamp [RING_DEPTH];
  logic [SLOT_W-1:0] ring_head     = '0;
  logic [SLOT_W-1:0] ring_unsent   = '0;
  int                seg_stored    = 0;
  int                seg_in_flight = 0;
  logic [SEQ_W-1:0]  seq_next      = '0;
  logic [SEQ_W-1:0]  tick_count    = '0;
  logic [WIN_W-1:0]  cur_window    = WINDOW_RESET;
  logic [TMO_W-1:0]  cur_timeout   = TIMEOUT_RESET;

  out_item_t step_tx[$];
  out_item_t pending_tx[$];
  out_item_t want_tx;

  int fail_count  = 0;
  int stall_left  = 0;
  int free_left   = 0;
  bit quiet_tail  = 1'b0;

  go_back_n_send_window uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic out_item_t make_tx(input logic [KIND_W-1:0] kind,
                                        input logic [SEQ_W-1:0] seq,
                                        input logic [LEN_W-1:0] len,
                                        input logic [SLOT_W-1:0] slot);
    out_item_t tx;
    tx.kind       = kind;
    tx.seq_num    = seq;
    tx.out_length = len;
    tx.slot       = slot;
    tx.last       = 1'b0;
    return tx;
  endfunction

  // Send unsent segments while the window has room
  function automatic void send_window();
    while (seg_in_flight < cur_window && seg_in_flight < seg_stored) begin
      ring_stamp[ring_unsent] = tick_count;
      step_tx.push_back(make_tx(KIND_FIRST, ring_seq[ring_unsent],
                                ring_len[ring_unsent], ring_unsent));
      seg_in_flight++;
      ring_unsent = ring_unsent + 1'b1;
    end
  endfunction

  // Advance the sender by one input and fill step_tx with its results
  function automatic void predict_step(input in_item_t it);
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] s;
    logic [SEQ_W-1:0]  elapsed;
    step_tx.delete();
    case (it.action)
      ACT_QUEUE: begin
        len = (it.seg_length > LEN_W'(SEG_BYTES_MAX)) ? LEN_W'(SEG_BYTES_MAX)
                                                      : it.seg_length;
        if (seg_stored >= RING_DEPTH) begin
          step_tx.push_back(make_tx(KIND_REJECT, seq_next, len, '0));
        end else begin
          s = ring_head + SLOT_W'(seg_stored);
          ring_seq[s]   = seq_next;
          ring_len[s]   = len;
          ring_stamp[s] = '0;
          seq_next      = seq_next + SEQ_W'(len);
          seg_stored++;
          send_window();
        end
      end
      ACT_ACK: begin
        if (seg_stored > 0 && it.ack_num >= ring_seq[ring_head]) begin
          // free acknowledged in-flight entries only
          while (seg_in_flight > 0 && ring_seq[ring_head] < it.ack_num) begin
            ring_head = ring_head + 1'b1;
            seg_in_flight--;
            seg_stored--;
          end
          send_window();
        end
      end
      ACT_TICK: begin
        tick_count = tick_count + 1'b1;
        if (seg_in_flight > 0) begin
          elapsed = tick_count - ring_stamp[ring_head];
          // head timed out: resend and restamp everything in flight
          if (elapsed > SEQ_W'(cur_timeout)) begin
            for (int i = 0; i < seg_in_flight; i++) begin
              s = ring_head + SLOT_W'(i);
              ring_stamp[s] = tick_count;
              step_tx.push_back(make_tx(KIND_RETX, ring_seq[s], ring_len[s], s));
            end
          end
        end
      end
      default: ;
    endcase
    if (step_tx.size() > 0) step_tx[step_tx.size() - 1].last = 1'b1;
  endfunction

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Present one input transaction, wait for it to be taken, record expectations
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t typed_tx);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_step(it);
    if (typed) pending_tx.push_back(typed_tx);
    else foreach (step_tx[k]) pending_tx.push_back(step_tx[k]);
  endtask

  // Drain all expected results, then give silent work time to finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [WIN_W-1:0] win, input logic [TMO_W-1:0] tmo);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_data  <= CFG_DATA_W'(win);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_window = win;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_timeout = tmo;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input phase_t ph, input bit quiet);
    in_item_t it;
    int       pick;
    int       k;
    int       sent;
    int       gap_pct;
    sent    = 0;
    gap_pct = 0;
    if (quiet) quiet_tail <= 1'b1;
    write_regs(ph.win, ph.tmo);
    while (sent < ph.items) begin
      if (!quiet && sent % 10 == 0) gap_pct = 25 * $urandom_range(0, 2);
      // unused fields carry random bits
      it.seg_length = LEN_W'($urandom);
      it.ack_num    = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < ph.queue_pct) begin
        it.action = ACT_QUEUE;
        pick = $urandom_range(0, 15);
        if (pick == 1) it.seg_length = $urandom_range(0, 1) ? LEN_W'(SEG_BYTES_MAX) : '0;
        else if (pick != 0) it.seg_length = LEN_W'($urandom_range(1, SEG_BYTES_MAX));
      end else if (pick < ph.queue_pct + ph.ack_pct) begin
        it.action = ACT_ACK;
        pick = $urandom_range(0, 9);
        if (seg_stored > 0 && pick < 7) begin
          // cumulative ack on a segment boundary within the in-flight span
          k = $urandom_range(0, seg_in_flight);
          it.ack_num = (k < seg_stored) ? ring_seq[ring_head + SLOT_W'(k)] : seq_next;
        end else if (pick == 7) begin
          it.ack_num = seq_next + $urandom_range(0, 2000);
        end else if (seg_stored > 0 && pick == 8) begin
          it.ack_num = $urandom_range(0, ring_seq[ring_head]);
        end
      end else if (pick < 97) begin
        it.action = ACT_TICK;
      end else begin
        it.action = ACT_UNUSED;
      end
      if ($urandom_range(1, 100) <= gap_pct) idle_gap($urandom_range(1, 8));
      offer_item(it, 1'b0, NO_TX);
      sent++;
    end
    settle();
  endtask

  // Check the output side and hold it off in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tx.size() == 0) begin
        note_failure($sformatf("unexpected transaction: kind=%0d seq=%0d len=%0d slot=%0d last=%0d",
                               out_data.kind, out_data.seq_num, out_data.out_length,
                               out_data.slot, out_data.last));
      end else begin
        want_tx = pending_tx.pop_front();
        if (out_data.kind !== want_tx.kind || out_data.seq_num !== want_tx.seq_num ||
            out_data.out_length !== want_tx.out_length || out_data.slot !== want_tx.slot ||
            out_data.last !== want_tx.last)
          note_failure($sformatf({"mismatch: expected kind=%0d seq=%0d len=%0d slot=%0d ",
                                  "last=%0d, got kind=%0d seq=%0d len=%0d slot=%0d last=%0d"},
                                 want_tx.kind, want_tx.seq_num, want_tx.out_length,
                                 want_tx.slot, want_tx.last, out_data.kind, out_data.seq_num,
                                 out_data.out_length, out_data.slot, out_data.last));
      end
    end
    if (quiet_tail) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 7);
      free_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset settings
    for (int r = 0; r < NUM_DIR; r++) begin
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 8));
      offer_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].tx);
    end
    settle();

    // random phases across register settings, the last without idling
    for (int p = 0; p < NUM_PHASES; p++) run_phase(PHASES[p], p == NUM_PHASES - 1);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/gbn_pkg.sv
design/gbn_front.sv
design/gbn_cmd_queue.sv
design/gbn_engine.sv
design/go_back_n_send_window.sv
design/gbn_checker.sv
tb/sv/tb_top.sv
